[rtl/tccs_pkg.sv]
// tccs_pkg: shared constants, payload structs and state codes of the text console
// depends on nothing; used by text_console_cursor_scroll_core
`default_nettype none

package tccs_pkg;

  // screen geometry
  localparam int TEXT_ROWS  = 30;
  localparam int TEXT_COLS  = 80;
  localparam int CELL_COUNT = TEXT_ROWS * TEXT_COLS;

  localparam int ROW_W   = $clog2(TEXT_ROWS);
  localparam int COL_W   = $clog2(TEXT_COLS);
  localparam int CELL_AW = $clog2(CELL_COUNT);

  // payload field widths
  localparam int FUNC_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int ADDR_W    = 12;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;

  // reciprocal of TEXT_COLS, exact for every 12-bit address
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 21;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + TEXT_COLS - 1) / TEXT_COLS);

  // character codes
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0] RETURN_CHAR  = 8'd13;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] ch;
    logic [ADDR_W-1:0] cell_addr;
  } req_t;

  typedef struct packed {
    logic [OUT_ROW_W-1:0] cursor_row;
    logic [OUT_COL_W-1:0] cursor_col;
    logic [CHAR_W-1:0]    read_data;
    logic                 scrolled;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PUT,
    S_FILL,
    S_RDIV,
    S_RADDR,
    S_RDATA
  } state_t;

endpackage

`default_nettype wire

[rtl/tccs_ram.sv]
// tccs_ram: generic single-port synchronous ram, read-before-write, registered read
// depends on nothing
`default_nettype none

module tccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

[rtl/text_console_cursor_scroll_core.sv]
// text_console_cursor_scroll_core: text console with cursor, scrolling and cell reads
// depends on tccs_pkg and tccs_ram
//
//  channel | ports                 | marks a beat
//  --------+-----------------------+---------------------------------
//  command | start, busy, req      | start high while busy is low
//  result  | done, rsp             | done high, one cycle, no stall
//
// a command passes these states before its result beat: exec alone for newline,
// carriage return, clear and the unused code; exec and put for a stored
// character; exec, divide by the row width, address, then ram read data for a
// read, the last skipped for an address off the screen or a fresh row. a
// character that lands on a row not written since reset, clear or scroll first
// sweeps that row with spaces through the single ram port. rows are mapped
// through a rotating base, so scroll and clear need no sweep of the ram. reset
// is synchronous; after it the block takes a command at once, with no clearing
// pass. the result side cannot stall; busy alone holds the command side.
`default_nettype none

module text_console_cursor_scroll_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire tccs_pkg::req_t req,
  output logic               done,
  output tccs_pkg::rsp_t     rsp
);

  import tccs_pkg::*;

  // logical row to physical ram row through the scroll base
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, b};
    if (sum >= (ROW_W+1)'(TEXT_ROWS)) begin
      sum = sum - (ROW_W+1)'(TEXT_ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [CELL_AW-1:0] cell_index(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
    return CELL_AW'(int'(r) * TEXT_COLS + int'(c));
  endfunction

  // control state
  state_t                 state, state_next;
  logic [ROW_W-1:0]       row, row_next;        // cursor row
  logic [COL_W-1:0]       col, col_next;        // cursor column
  logic [ROW_W-1:0]       base, base_next;      // physical row of logical row 0
  logic [TEXT_ROWS-1:0]   row_valid, row_valid_next;  // physical row holds real data
  logic                   done_next;

  // payload registers
  req_t                   req_q, req_next;
  logic                   scrolled_q, scrolled_next;
  logic [COL_W-1:0]       fill_cnt, fill_next;
  logic [ADDR_W-1:0]      quot, quot_next;
  rsp_t                   rsp_next;

  // ram port
  logic                   mem_we;
  logic [CELL_AW-1:0]     mem_addr;
  logic [CHAR_W-1:0]      mem_wdata;
  logic [CHAR_W-1:0]      mem_rdata;

  // helpers
  logic [ROW_W-1:0]       put_phys;
  logic                   at_bottom;
  logic [ROW_W-1:0]       adv_row;
  logic [ROW_W-1:0]       adv_base;
  logic [ADDR_W+RECIP_W-1:0] prod;
  logic [ROW_W-1:0]       rd_phys;
  logic [COL_W-1:0]       rd_col;
  int                     rem;
  logic [CHAR_W-1:0]      res_data;

  tccs_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (CELL_COUNT)
  ) u_buf (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign busy = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // cursor, row map and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      row       <= '0;
      col       <= '0;
      base      <= '0;
      row_valid <= '0;
      done      <= 1'b0;
    end else begin
      row       <= row_next;
      col       <= col_next;
      base      <= base_next;
      row_valid <= row_valid_next;
      done      <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    req_q      <= req_next;
    scrolled_q <= scrolled_next;
    fill_cnt   <= fill_next;
    quot       <= quot_next;
    rsp        <= rsp_next;
  end

  // new line: down one row, or scroll by rotating the base on the last row
  assign put_phys  = phys_row(row, base);
  assign at_bottom = (row >= ROW_W'(TEXT_ROWS - 1));
  assign adv_row   = at_bottom ? ROW_W'(TEXT_ROWS - 1) : row + ROW_W'(1);
  assign adv_base  = !at_bottom ? base :
                     (base == ROW_W'(TEXT_ROWS - 1)) ? '0 : base + ROW_W'(1);

  // cell address split: row by reciprocal, then column by remainder
  assign prod    = (ADDR_W+RECIP_W)'(req_q.cell_addr) * (ADDR_W+RECIP_W)'(RECIP);
  assign rem     = int'(req_q.cell_addr) - int'(quot) * TEXT_COLS;
  assign rd_col  = COL_W'(rem);
  assign rd_phys = phys_row(quot[ROW_W-1:0], base);

  always_comb begin
    state_next     = state;
    row_next       = row;
    col_next       = col;
    base_next      = base;
    row_valid_next = row_valid;
    done_next      = 1'b0;
    req_next       = req_q;
    scrolled_next  = scrolled_q;
    fill_next      = fill_cnt;
    quot_next      = quot;
    rsp_next       = rsp;
    res_data       = '0;
    mem_we         = 1'b0;
    mem_addr       = cell_index(put_phys, col);
    mem_wdata      = req_q.ch;

    case (state)
      S_IDLE: begin
        if (start) begin
          req_next   = req;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        scrolled_next = 1'b0;
        case (req_q.func)
          FUNC_PUT: begin
            if (req_q.ch == NEWLINE_CHAR) begin
              col_next      = '0;
              row_next      = adv_row;
              base_next     = adv_base;
              scrolled_next = at_bottom;
              if (at_bottom) begin
                row_valid_next[base] = 1'b0;
              end
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else if (req_q.ch == RETURN_CHAR) begin
              col_next   = '0;
              done_next  = 1'b1;
              state_next = S_IDLE;
            end else begin
              // wrap before storing when the cursor sits in the last column
              if (col >= COL_W'(TEXT_COLS - 1)) begin
                col_next      = '0;
                row_next      = adv_row;
                base_next     = adv_base;
                scrolled_next = at_bottom;
                if (at_bottom) begin
                  row_valid_next[base] = 1'b0;
                end
              end
              state_next = S_PUT;
            end
          end
          FUNC_CLEAR: begin
            row_valid_next = '0;
            base_next      = '0;
            row_next       = '0;
            col_next       = '0;
            done_next      = 1'b1;
            state_next     = S_IDLE;
          end
          FUNC_READ: begin
            state_next = S_RDIV;
          end
          default: begin
            done_next  = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end

      S_PUT: begin
        if (row_valid[put_phys]) begin
          mem_we     = 1'b1;
          col_next   = col + COL_W'(1);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          fill_next  = '0;
          state_next = S_FILL;
        end
      end

      S_FILL: begin
        // fresh row: write spaces across it before the character lands
        mem_we    = 1'b1;
        mem_addr  = cell_index(put_phys, fill_cnt);
        mem_wdata = SPACE_CHAR;
        fill_next = fill_cnt + COL_W'(1);
        if (fill_cnt == COL_W'(TEXT_COLS - 1)) begin
          row_valid_next[put_phys] = 1'b1;
          state_next               = S_PUT;
        end
      end

      S_RDIV: begin
        quot_next  = prod[RECIP_SHIFT +: ADDR_W];
        state_next = S_RADDR;
      end

      S_RADDR: begin
        if (int'(req_q.cell_addr) >= CELL_COUNT) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else if (!row_valid[rd_phys]) begin
          res_data   = SPACE_CHAR;
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          mem_addr   = cell_index(rd_phys, rd_col);
          state_next = S_RDATA;
        end
      end

      S_RDATA: begin
        res_data   = mem_rdata;
        done_next  = 1'b1;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (done_next) begin
      rsp_next.cursor_row = OUT_ROW_W'(row_next);
      rsp_next.cursor_col = OUT_COL_W'(col_next);
      rsp_next.read_data  = res_data;
      rsp_next.scrolled   = scrolled_next;
    end
  end

  // the cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (int'(row) < TEXT_ROWS) && (int'(col) < TEXT_COLS))
    else $error("cursor outside the screen");

  // a result beat only follows work in progress
  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state != S_IDLE))
    else $error("result beat without a command in flight");

  // no result in the cycle right after a command beat
  a_no_early_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result beat too early");

  // a row sweep only runs over a row that holds no data yet
  a_fill_fresh_row: assert property (@(posedge clk) disable iff (rst)
    (state == S_FILL) |-> !row_valid[put_phys])
    else $error("sweep over a live row");

endmodule

`default_nettype wire
